// ===== sv/arat_pkg.sv =====
// package for the address range table allocator
// holds sizes, mode and status codes and the sequencer state type; no dependencies
`default_nettype none
package arat_pkg;
  localparam int MAX_RANGES = 32;
  localparam int ADDR_W     = 32;
  localparam int IDXW       = $clog2(MAX_RANGES);
  localparam int CNTW       = $clog2(MAX_RANGES + 1);
  localparam int ENTW       = 2 * ADDR_W;

  localparam logic [2:0] MODE_APPEND   = 3'd0;
  localparam logic [2:0] MODE_REMOVE   = 3'd1;
  localparam logic [2:0] MODE_ALLOCATE = 3'd2;
  localparam logic [2:0] MODE_MERGE    = 3'd3;
  localparam logic [2:0] MODE_READ     = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_PARTIAL  = 3'd2;
  localparam logic [2:0] ST_SPLIT    = 3'd3;
  localparam logic [2:0] ST_NOFIT    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE, S_APP, S_RD_RQ, S_RD_EV,
    S_CUT_FRD, S_CUT_FEV, S_CUT_LRD, S_CUT_LEV, S_CUT_PROC,
    S_INS_RD, S_INS_EV, S_INS_W1, S_INS_W0, S_DEL_RD, S_DEL_EV,
    S_ALC_RD, S_ALC_EV,
    S_SRT_I, S_SRT_KEY, S_SRT_RD, S_SRT_EV,
    S_MRG_I, S_MRG_A, S_MRG_J, S_MRG_JE, S_MRG_W,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== sv/arat_if.sv =====
// valid/ready channel interfaces for request and result beats
// depends on arat_pkg for the address width
`default_nettype none
interface arat_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic [arat_pkg::ADDR_W-1:0] start_address;
  logic [arat_pkg::ADDR_W-1:0] length;
  logic [arat_pkg::ADDR_W-1:0] alignment;
  logic                      require_hit;
  logic [4:0]                entry_index;
  modport source (output valid, mode, start_address, length, alignment, require_hit,
                  entry_index, input ready);
  modport sink (input valid, mode, start_address, length, alignment, require_hit,
                entry_index, output ready);
endinterface

interface arat_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [arat_pkg::ADDR_W-1:0] result_address;
  logic [arat_pkg::ADDR_W-1:0] result_length;
  logic [5:0]                range_count;
  modport source (output valid, status, result_address, result_length, range_count,
                  input ready);
  modport sink (input valid, status, result_address, result_length, range_count,
                output ready);
endinterface
`default_nettype wire

// ===== sv/address_range_table_allocator_unit.sv =====
// address range table allocator: one item at a time through a sequencer around one ram
// invalid modes go straight to the result, append writes one entry, read fetches one entry
// if its index is in range, remove scans and shifts entries, allocate tries entries first,
// merge sorts then merges the table; a result held at the output stalls the input
// reset clears the sequencer, the entry count and output valid; the table ram is not cleared
// depends on arat_pkg, arat_if and arat_ram
`default_nettype none
module address_range_table_allocator_unit (
  input wire logic clk,
  input wire logic rst_n,
  arat_in_if.sink    in_ch,
  arat_out_if.source out_ch
);
  localparam int A  = arat_pkg::ADDR_W;
  localparam int IW = arat_pkg::IDXW;
  localparam int CW = arat_pkg::CNTW;
  localparam int EW = arat_pkg::ENTW;

  arat_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] total_r, total_nxt, i_r, i_nxt, j_r, j_nxt, d_r, d_nxt;
  logic [A-1:0]  start_r, start_nxt, end_r, end_nxt, size_r, size_nxt;
  logic [A-1:0]  align_r, align_nxt, rs_r, rs_nxt, re_r, re_nxt;
  logic [A-1:0]  res_addr_r, res_addr_nxt, res_len_r, res_len_nxt;
  logic [EW-1:0] key_r, key_nxt;
  logic [4:0]    idx_r, idx_nxt;
  logic          must_r, must_nxt;
  logic [2:0]    st_r, st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r;
  logic [A-1:0]  out_addr_r, out_len_r;
  logic [5:0]    out_count_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  arat_ram #(.WIDTH(EW), .DEPTH(arat_pkg::MAX_RANGES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [A-1:0]  rd_base, rd_len, rd_end, al_a, key_base;
  logic [CW-1:0] i_inc, j_inc, j_dec;
  logic          in_acc, out_free, i_lt_tot, j_lt_tot, full, overlap, fit;
  logic          cut_left, cut_right, ins_more, del_more, idx_ok;

  assign rd_base  = ram_rdata[EW-1:A];
  assign rd_len   = ram_rdata[A-1:0];
  assign rd_end   = rd_base + rd_len;
  assign key_base = key_r[EW-1:A];
  assign al_a     = (rd_base + align_r - A'(1)) & (A'(0) - align_r);
  assign fit      = (al_a + size_r) <= rd_end;
  assign i_inc    = i_r + CW'(1);
  assign j_inc    = j_r + CW'(1);
  assign j_dec    = j_r - CW'(1);
  assign i_lt_tot = i_r < total_r;
  assign j_lt_tot = j_r < total_r;
  assign full     = total_r >= CW'(arat_pkg::MAX_RANGES);
  assign overlap  = (end_r > rd_base) && (start_r < rd_end);
  assign cut_left  = start_r > rs_r;
  assign cut_right = end_r < re_r;
  assign ins_more = j_r > i_inc;
  assign del_more = j_inc < total_r;
  assign idx_ok   = 32'(idx_r) < 32'(total_r);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = state_r == arat_pkg::S_IDLE;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.result_length  = out_len_r;
  assign out_ch.range_count    = out_count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arat_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            arat_pkg::MODE_APPEND:   state_nxt = arat_pkg::S_APP;
            arat_pkg::MODE_REMOVE:   state_nxt = arat_pkg::S_CUT_FRD;
            arat_pkg::MODE_ALLOCATE: state_nxt = arat_pkg::S_ALC_RD;
            arat_pkg::MODE_MERGE:    state_nxt = arat_pkg::S_SRT_I;
            arat_pkg::MODE_READ:     state_nxt = arat_pkg::S_RD_RQ;
            default:                 state_nxt = arat_pkg::S_DONE;
          endcase
        end
      end
      arat_pkg::S_APP:   state_nxt = arat_pkg::S_DONE;
      arat_pkg::S_RD_RQ: state_nxt = idx_ok ? arat_pkg::S_RD_EV : arat_pkg::S_DONE;
      arat_pkg::S_RD_EV: state_nxt = arat_pkg::S_DONE;
      arat_pkg::S_CUT_FRD: state_nxt = i_lt_tot ? arat_pkg::S_CUT_FEV : arat_pkg::S_DONE;
      arat_pkg::S_CUT_FEV: state_nxt = overlap ? arat_pkg::S_CUT_PROC : arat_pkg::S_CUT_FRD;
      arat_pkg::S_CUT_LRD: state_nxt = i_lt_tot ? arat_pkg::S_CUT_LEV : arat_pkg::S_DONE;
      arat_pkg::S_CUT_LEV: begin
        if (!(end_r > rd_base)) begin
          state_nxt = arat_pkg::S_DONE;
        end else if (!(start_r < rd_end)) begin
          state_nxt = arat_pkg::S_CUT_LRD;
        end else begin
          state_nxt = arat_pkg::S_CUT_PROC;
        end
      end
      arat_pkg::S_CUT_PROC: begin
        if (cut_left && cut_right) begin
          state_nxt = full ? arat_pkg::S_DONE : arat_pkg::S_INS_RD;
        end else if (cut_left || cut_right) begin
          state_nxt = arat_pkg::S_CUT_LRD;
        end else begin
          state_nxt = arat_pkg::S_DEL_RD;
        end
      end
      arat_pkg::S_INS_RD: state_nxt = ins_more ? arat_pkg::S_INS_EV : arat_pkg::S_INS_W1;
      arat_pkg::S_INS_EV: state_nxt = arat_pkg::S_INS_RD;
      arat_pkg::S_INS_W1: state_nxt = arat_pkg::S_INS_W0;
      arat_pkg::S_INS_W0: state_nxt = arat_pkg::S_CUT_LRD;
      arat_pkg::S_DEL_RD: state_nxt = del_more ? arat_pkg::S_DEL_EV : arat_pkg::S_CUT_LRD;
      arat_pkg::S_DEL_EV: state_nxt = arat_pkg::S_DEL_RD;
      arat_pkg::S_ALC_RD: state_nxt = i_lt_tot ? arat_pkg::S_ALC_EV : arat_pkg::S_DONE;
      arat_pkg::S_ALC_EV: state_nxt = fit ? arat_pkg::S_CUT_FRD : arat_pkg::S_ALC_RD;
      arat_pkg::S_SRT_I:  state_nxt = i_lt_tot ? arat_pkg::S_SRT_KEY : arat_pkg::S_MRG_I;
      arat_pkg::S_SRT_KEY: state_nxt = arat_pkg::S_SRT_RD;
      arat_pkg::S_SRT_RD: state_nxt = (j_r != '0) ? arat_pkg::S_SRT_EV : arat_pkg::S_SRT_I;
      arat_pkg::S_SRT_EV: begin
        state_nxt = (key_base < rd_base) ? arat_pkg::S_SRT_RD : arat_pkg::S_SRT_I;
      end
      arat_pkg::S_MRG_I:  state_nxt = i_lt_tot ? arat_pkg::S_MRG_A : arat_pkg::S_DONE;
      arat_pkg::S_MRG_A:  state_nxt = arat_pkg::S_MRG_J;
      arat_pkg::S_MRG_J:  state_nxt = j_lt_tot ? arat_pkg::S_MRG_JE : arat_pkg::S_MRG_W;
      arat_pkg::S_MRG_JE: state_nxt = (rd_base <= re_r) ? arat_pkg::S_MRG_J : arat_pkg::S_MRG_W;
      arat_pkg::S_MRG_W:  state_nxt = arat_pkg::S_MRG_I;
      arat_pkg::S_DONE:   state_nxt = out_free ? arat_pkg::S_IDLE : arat_pkg::S_DONE;
      default:            state_nxt = arat_pkg::S_IDLE;
    endcase
  end

  // datapath, ram port and result register controls
  always_comb begin
    total_nxt = total_r; i_nxt = i_r; j_nxt = j_r; d_nxt = d_r;
    start_nxt = start_r; end_nxt = end_r; size_nxt = size_r; align_nxt = align_r;
    rs_nxt = rs_r; re_nxt = re_r; key_nxt = key_r; idx_nxt = idx_r;
    must_nxt = must_r; st_nxt = st_r;
    res_addr_nxt = res_addr_r; res_len_nxt = res_len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    case (state_r)
      arat_pkg::S_IDLE: begin
        if (in_acc) begin
          start_nxt = in_ch.start_address;
          size_nxt  = in_ch.length;
          end_nxt   = in_ch.start_address + in_ch.length;
          align_nxt = in_ch.alignment;
          must_nxt  = in_ch.require_hit;
          idx_nxt   = in_ch.entry_index;
          st_nxt    = arat_pkg::ST_OK;
          res_addr_nxt = '0;
          res_len_nxt  = '0;
          i_nxt = (in_ch.mode == arat_pkg::MODE_MERGE) ? CW'(1) : '0;
        end
      end
      arat_pkg::S_APP: begin
        if (full) begin
          st_nxt = arat_pkg::ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = total_r[IW-1:0];
          ram_wdata = {start_r, size_r};
          total_nxt = total_r + CW'(1);
        end
      end
      arat_pkg::S_RD_RQ: begin
        ram_raddr = IW'(idx_r);
        if (!idx_ok) st_nxt = arat_pkg::ST_NOTFOUND;
      end
      arat_pkg::S_RD_EV: begin
        res_addr_nxt = rd_base;
        res_len_nxt  = rd_len;
      end
      arat_pkg::S_CUT_FRD: begin
        ram_raddr = i_r[IW-1:0];
        if (!i_lt_tot) st_nxt = must_r ? arat_pkg::ST_NOTFOUND : arat_pkg::ST_OK;
      end
      arat_pkg::S_CUT_FEV: begin
        if (overlap) begin
          rs_nxt = rd_base;
          re_nxt = rd_end;
        end else begin
          i_nxt = i_inc;
        end
      end
      arat_pkg::S_CUT_LRD: ram_raddr = i_r[IW-1:0];
      arat_pkg::S_CUT_LEV: begin
        if (end_r > rd_base) begin
          if (!(start_r < rd_end)) begin
            i_nxt = i_inc;
          end else begin
            rs_nxt = rd_base;
            re_nxt = rd_end;
          end
        end
      end
      arat_pkg::S_CUT_PROC: begin
        if (must_r && (start_r < rs_r || end_r > re_r)) begin
          st_nxt   = arat_pkg::ST_PARTIAL;
          must_nxt = 1'b0;
        end
        if (cut_left && cut_right) begin
          if (full) st_nxt = arat_pkg::ST_SPLIT;
          else j_nxt = total_r;
        end else if (cut_left) begin
          ram_we    = 1'b1;
          ram_waddr = i_r[IW-1:0];
          ram_wdata = {rs_r, start_r - rs_r};
          i_nxt     = i_inc;
        end else if (cut_right) begin
          ram_we    = 1'b1;
          ram_waddr = i_r[IW-1:0];
          ram_wdata = {end_r, re_r - end_r};
          i_nxt     = i_inc;
        end else begin
          j_nxt = i_r;
        end
      end
      arat_pkg::S_INS_RD: ram_raddr = j_dec[IW-1:0];
      arat_pkg::S_INS_EV: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IW-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_dec;
      end
      arat_pkg::S_INS_W1: begin
        ram_we    = 1'b1;
        ram_waddr = i_inc[IW-1:0];
        ram_wdata = {end_r, re_r - end_r};
        total_nxt = total_r + CW'(1);
      end
      arat_pkg::S_INS_W0: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[IW-1:0];
        ram_wdata = {rs_r, start_r - rs_r};
        i_nxt     = i_inc;
      end
      arat_pkg::S_DEL_RD: begin
        ram_raddr = j_inc[IW-1:0];
        if (!del_more) total_nxt = total_r - CW'(1);
      end
      arat_pkg::S_DEL_EV: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IW-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_inc;
      end
      arat_pkg::S_ALC_RD: begin
        ram_raddr = i_r[IW-1:0];
        if (!i_lt_tot) st_nxt = arat_pkg::ST_NOFIT;
      end
      arat_pkg::S_ALC_EV: begin
        if (fit) begin
          start_nxt    = al_a;
          end_nxt      = al_a + size_r;
          must_nxt     = 1'b1;
          res_addr_nxt = al_a;
          i_nxt        = '0;
        end else begin
          i_nxt = i_inc;
        end
      end
      arat_pkg::S_SRT_I: begin
        ram_raddr = i_r[IW-1:0];
        if (!i_lt_tot) begin
          i_nxt = '0;
          d_nxt = '0;
        end
      end
      arat_pkg::S_SRT_KEY: begin
        key_nxt = ram_rdata;
        j_nxt   = i_r;
      end
      arat_pkg::S_SRT_RD: begin
        ram_raddr = j_dec[IW-1:0];
        if (j_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[IW-1:0];
          ram_wdata = key_r;
          i_nxt     = i_inc;
        end
      end
      arat_pkg::S_SRT_EV: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IW-1:0];
        if (key_base < rd_base) begin
          ram_wdata = ram_rdata;
          j_nxt     = j_dec;
        end else begin
          ram_wdata = key_r;
          i_nxt     = i_inc;
        end
      end
      arat_pkg::S_MRG_I: begin
        ram_raddr = i_r[IW-1:0];
        if (!i_lt_tot) total_nxt = d_r;
      end
      arat_pkg::S_MRG_A: begin
        rs_nxt = rd_base;
        re_nxt = rd_end;
        j_nxt  = i_inc;
      end
      arat_pkg::S_MRG_J: ram_raddr = j_r[IW-1:0];
      arat_pkg::S_MRG_JE: begin
        if (rd_base <= re_r) begin
          if (rd_end > re_r) re_nxt = rd_end;
          j_nxt = j_inc;
        end
      end
      arat_pkg::S_MRG_W: begin
        ram_we    = 1'b1;
        ram_waddr = d_r[IW-1:0];
        ram_wdata = {rs_r, re_r - rs_r};
        d_nxt     = d_r + CW'(1);
        i_nxt     = j_r;
      end
      arat_pkg::S_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arat_pkg::S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; d_r <= d_nxt;
    start_r <= start_nxt; end_r <= end_nxt; size_r <= size_nxt; align_r <= align_nxt;
    rs_r <= rs_nxt; re_r <= re_nxt; key_r <= key_nxt; idx_r <= idx_nxt;
    must_r <= must_nxt; st_r <= st_nxt;
    res_addr_r <= res_addr_nxt; res_len_r <= res_len_nxt;
    // result beat is loaded when the output register is free
    if (state_r == arat_pkg::S_DONE && out_free) begin
      out_status_r <= st_r;
      out_addr_r   <= res_addr_r;
      out_len_r    <= res_len_r;
      out_count_r  <= 6'(total_r);
    end
  end
endmodule
`default_nettype wire

// ===== sv/arat_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none
module arat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
